// File: hdl/fslcs_pkg.sv
// fslcs_pkg: shared types and constants for the framed serial light command slave
// used by fslcs_core, fslcs_tx and framed_serial_light_command_slave
`default_nettype none

package fslcs_pkg;

  // frame bytes
  localparam logic [7:0] HDR1  = 8'h10;
  localparam logic [7:0] HDR2  = 8'h18;
  localparam logic [7:0] BCAST = 8'hFF;

  // commands
  localparam logic [2:0] CMD_ON     = 3'd1;
  localparam logic [2:0] CMD_OFF    = 3'd2;
  localparam logic [2:0] CMD_STATUS = 3'd3;
  localparam logic [2:0] CMD_INVERT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS     = 2'd0;
  localparam logic [1:0] CFG_FRAME_TIMEOUT      = 2'd1;
  localparam logic [1:0] CFG_SAVE_DELAY         = 2'd2;
  localparam logic [1:0] CFG_REPLY_TO_BROADCAST = 2'd3;

  // reset values of the configuration registers
  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h06;
  localparam logic [7:0]  FRAME_TIMEOUT_RST  = 8'd50;
  localparam logic [15:0] SAVE_DELAY_RST     = 16'd2000;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [7:0]  frame_timeout_ticks;
    logic [15:0] save_delay_ticks;
    logic        reply_to_broadcast;
  } cfg_t;

  // everything the result side needs for one accepted item
  typedef struct packed {
    logic       reply;
    logic [7:0] address;
    logic [2:0] command;
    logic       light;
    logic       strobe;
    logic       save_value;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/framed_serial_light_command_slave.sv
// framed_serial_light_command_slave: top level with configuration registers
// depends on fslcs_pkg, fslcs_core and fslcs_tx
//
// input channel (in_valid/in_ready): mode 0 carries a received byte in rx_byte,
// mode 1 marks a one millisecond tick. each accepted item gives one result,
// or seven when a completed frame asks for a reply (10 18 addr cmd state 18 10).
// output channel (out_valid/out_ready): one result per transfer, last marks the
// final result of an item. the first result is ready in the cycle after the input
// transfer; a reply then takes seven output transfers. the block takes one item
// per cycle for bytes and ticks while out_ready stays high; a replying frame
// holds off the next item until its last result leaves the single result register.
// the next input is taken in the same cycle as the final result of the previous
// item leaves, so a stalled receiver stalls the input through in_ready.
// configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and
// should be written while the block is idle.
// reset: parser idle, light off, no save pending, registers at address 06,
// frame timeout 50 ticks, save delay 2000 ticks, no broadcast replies.
`default_nettype none

module framed_serial_light_command_slave
  import fslcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             tx_valid,
  output logic [7:0]       tx_byte,
  output logic             last,
  output logic             light_on,
  output logic             save_strobe,
  output logic             save_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t cfg;
  res_t res;
  logic can_load;
  logic fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign fire      = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address      <= DEVICE_ADDRESS_RST;
      cfg.frame_timeout_ticks <= FRAME_TIMEOUT_RST;
      cfg.save_delay_ticks    <= SAVE_DELAY_RST;
      cfg.reply_to_broadcast  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS:     cfg.device_address      <= cfg_data[7:0];
        CFG_FRAME_TIMEOUT:      cfg.frame_timeout_ticks <= cfg_data[7:0];
        CFG_SAVE_DELAY:         cfg.save_delay_ticks    <= cfg_data;
        CFG_REPLY_TO_BROADCAST: cfg.reply_to_broadcast  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  fslcs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .mode    (mode),
    .rx_byte (rx_byte),
    .res     (res)
  );

  fslcs_tx u_tx (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .res_in      (res),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .last        (last),
    .light_on    (light_on),
    .save_strobe (save_strobe),
    .save_value  (save_value)
  );

endmodule

`default_nettype wire

// File: hdl/fslcs_core.sv
// fslcs_core: frame parser, light state, frame timeout and deferred-save countdown
// depends on fslcs_pkg
`default_nettype none

module fslcs_core
  import fslcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       fire,
  input  wire logic       mode,
  input  wire logic [7:0] rx_byte,
  output res_t            res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HDR2  = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_CMD   = 3'd3;
  localparam logic [2:0] PH_TAIL1 = 3'd4;
  localparam logic [2:0] PH_TAIL2 = 3'd5;

  logic [2:0]  parser_phase, parser_phase_next;
  logic [7:0]  frame_timer, frame_timer_next;
  logic [7:0]  held_address, held_address_next;
  logic [2:0]  held_command, held_command_next;
  logic        light_level, light_level_next;
  logic        save_pending, save_pending_next;
  logic [15:0] save_countdown, save_countdown_next;
  logic        pending_value, pending_value_next;

  logic        complete;
  logic        addr_ok;
  logic        changed;
  logic [15:0] cd_dec;

  always_comb begin
    parser_phase_next   = parser_phase;
    frame_timer_next    = frame_timer;
    held_address_next   = held_address;
    held_command_next   = held_command;
    light_level_next    = light_level;
    save_pending_next   = save_pending;
    save_countdown_next = save_countdown;
    pending_value_next  = pending_value;
    complete = 1'b0;
    changed  = 1'b0;
    cd_dec   = (save_countdown != 16'd0) ? save_countdown - 16'd1 : save_countdown;
    addr_ok  = (held_address == cfg.device_address) || (held_address == BCAST);

    res.reply      = 1'b0;
    res.address    = cfg.device_address;
    res.command    = held_command;
    res.light      = light_level;
    res.strobe     = 1'b0;
    res.save_value = 1'b0;

    if (mode) begin
      if (frame_timer != 8'd0) begin
        frame_timer_next = frame_timer - 8'd1;
        if (frame_timer == 8'd1) begin
          parser_phase_next = PH_IDLE;
        end
      end
      if (save_pending) begin
        save_countdown_next = cd_dec;
        if (cd_dec == 16'd0) begin
          save_pending_next = 1'b0;
          res.strobe        = 1'b1;
          res.save_value    = pending_value;
        end
      end
    end else begin
      case (parser_phase)
        PH_IDLE: begin
          if (rx_byte == HDR1) begin
            parser_phase_next = PH_HDR2;
            frame_timer_next  = cfg.frame_timeout_ticks;
          end
        end
        PH_HDR2: begin
          if (rx_byte == HDR2) begin
            parser_phase_next = PH_ADDR;
          end else if (rx_byte == HDR1) begin
            frame_timer_next = cfg.frame_timeout_ticks;
          end else begin
            parser_phase_next = PH_IDLE;
            frame_timer_next  = 8'd0;
          end
        end
        PH_ADDR, PH_CMD, PH_TAIL1: begin
          if (parser_phase == PH_ADDR &&
              (rx_byte == cfg.device_address || rx_byte == BCAST)) begin
            held_address_next = rx_byte;
            parser_phase_next = PH_CMD;
          end else if (parser_phase == PH_CMD && rx_byte >= 8'd1 && rx_byte <= 8'd4) begin
            held_command_next = rx_byte[2:0];
            parser_phase_next = PH_TAIL1;
          end else if (parser_phase == PH_TAIL1 && rx_byte == HDR2) begin
            parser_phase_next = PH_TAIL2;
          end else if (rx_byte == HDR1) begin
            // stray header restarts the frame
            parser_phase_next = PH_HDR2;
            frame_timer_next  = cfg.frame_timeout_ticks;
          end else begin
            parser_phase_next = PH_IDLE;
            frame_timer_next  = 8'd0;
          end
        end
        PH_TAIL2: begin
          parser_phase_next = PH_IDLE;
          frame_timer_next  = 8'd0;
          complete          = (rx_byte == HDR1);
        end
        default: begin
          parser_phase_next = PH_IDLE;
          frame_timer_next  = 8'd0;
        end
      endcase

      if (complete && addr_ok) begin
        case (held_command)
          CMD_ON: begin
            if (!light_level) begin
              light_level_next = 1'b1;
              changed          = 1'b1;
            end
          end
          CMD_OFF: begin
            if (light_level) begin
              light_level_next = 1'b0;
              changed          = 1'b1;
            end
          end
          CMD_INVERT: begin
            light_level_next = ~light_level;
            changed          = 1'b1;
          end
          default: begin
          end
        endcase
        if (changed) begin
          pending_value_next  = light_level_next;
          save_pending_next   = 1'b1;
          save_countdown_next = cfg.save_delay_ticks;
        end
        res.reply = (held_address == cfg.device_address) ||
                    (held_address == BCAST && cfg.reply_to_broadcast);
      end
      res.light = light_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parser_phase   <= PH_IDLE;
      frame_timer    <= 8'd0;
      held_address   <= 8'd0;
      held_command   <= 3'd0;
      light_level    <= 1'b0;
      save_pending   <= 1'b0;
      save_countdown <= 16'd0;
      pending_value  <= 1'b0;
    end else if (fire) begin
      parser_phase   <= parser_phase_next;
      frame_timer    <= frame_timer_next;
      held_address   <= held_address_next;
      held_command   <= held_command_next;
      light_level    <= light_level_next;
      save_pending   <= save_pending_next;
      save_countdown <= save_countdown_next;
      pending_value  <= pending_value_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/fslcs_tx.sv
// fslcs_tx: result register and reply serializer, one result per transfer
// depends on fslcs_pkg
`default_nettype none

module fslcs_tx
  import fslcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire res_t       res_in,
  output logic            can_load,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            last,
  output logic            light_on,
  output logic            save_strobe,
  output logic            save_value
);

  localparam logic [2:0] POS_HDR1A = 3'd0;
  localparam logic [2:0] POS_HDR2A = 3'd1;
  localparam logic [2:0] POS_ADDR  = 3'd2;
  localparam logic [2:0] POS_CMD   = 3'd3;
  localparam logic [2:0] POS_STATE = 3'd4;
  localparam logic [2:0] POS_HDR2B = 3'd5;
  localparam logic [2:0] POS_LAST  = 3'd6;

  logic       busy;
  logic [2:0] pos;
  res_t       held;

  always_comb begin
    last = !held.reply || (pos == POS_LAST);
    case (pos)
      POS_HDR1A: tx_byte = HDR1;
      POS_HDR2A: tx_byte = HDR2;
      POS_ADDR:  tx_byte = held.address;
      POS_CMD:   tx_byte = {5'd0, held.command};
      POS_STATE: tx_byte = {7'd0, held.light};
      POS_HDR2B: tx_byte = HDR2;
      POS_LAST:  tx_byte = HDR1;
      default:   tx_byte = 8'd0;
    endcase
    if (!held.reply) begin
      tx_byte = 8'd0;
    end
  end

  assign out_valid   = busy;
  assign tx_valid    = held.reply;
  assign light_on    = held.light;
  assign save_strobe = held.strobe;
  assign save_value  = held.save_value;
  // a new item may enter while the final result of the previous one leaves
  assign can_load    = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_HDR1A;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= POS_HDR1A;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res_in;
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_framed_serial_light_command_slave.sv
`timescale 1ns / 1ps
// tb_framed_serial_light_command_slave: self-checking testbench for the light command slave
// drives received bytes and ticks, predicts every result with its own frame and save model
// depends on fslcs_pkg and the rtl of framed_serial_light_command_slave

module tb_framed_serial_light_command_slave;
  import fslcs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 20;
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HDR2, PH_ADDR, PH_CMD, PH_TAIL1, PH_TAIL2
  } frame_phase_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       light_on;
    logic       save_strobe;
    logic       save_value;
  } slave_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        last;
  logic        light_on;
  logic        save_strobe;
  logic        save_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_DEVICE_ADDRESS;
  logic [15:0] cfg_data = 16'h0000;

  framed_serial_light_command_slave dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .last        (last),
    .light_on    (light_on),
    .save_strobe (save_strobe),
    .save_value  (save_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // light slave model state
  cfg_t          slave_cfg;
  frame_phase_t  rx_phase;
  logic [7:0]    frame_timer;
  logic [7:0]    held_addr;
  logic [2:0]    held_cmd;
  logic          light;
  logic          save_armed;
  logic [15:0]   save_count;
  logic          save_level;
  slave_result_t expected_results[$];
  slave_result_t want_result;

  int mismatch_count = 0;
  int results_seen   = 0;
  int items_sent     = 0;
  int ticks_sent     = 0;
  int reply_frames   = 0;
  int save_strobes   = 0;
  int config_writes  = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  bit gaps_on        = 1'b1;

  // receiver stall pattern and long hold-off
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;
  int   pat_count = 0;
  int   stall_pct = 0;

  function automatic void push_result(logic txv, logic [7:0] b, logic lst, logic strb,
                                      logic sv);
    expected_results.push_back('{txv, b, lst, light, strb, sv});
  endfunction

  function automatic void restart_frame(logic [7:0] b);
    if (b == HDR1) begin
      rx_phase = PH_HDR2;
      frame_timer = slave_cfg.frame_timeout_ticks;
    end else begin
      rx_phase = PH_IDLE;
      frame_timer = 8'h00;
    end
  endfunction

  function automatic void arm_save();
    save_level = light;
    save_armed = 1'b1;
    save_count = slave_cfg.save_delay_ticks;
  endfunction

  function automatic void predict_item(logic m, logic [7:0] b);
    logic       complete;
    logic       strobe;
    logic       kept;
    logic       reply;
    logic [7:0] frame_bytes [7];
    complete = 1'b0;
    strobe = 1'b0;
    kept = 1'b0;
    reply = 1'b0;
    if (m == MODE_TICK) begin
      ticks_sent++;
      if (frame_timer != 8'h00) begin
        frame_timer--;
        if (frame_timer == 8'h00) rx_phase = PH_IDLE;
      end
      if (save_armed) begin
        if (save_count != 16'h0000) save_count--;
        if (save_count == 16'h0000) begin
          save_armed = 1'b0;
          strobe = 1'b1;
          kept = save_level;
          save_strobes++;
        end
      end
      push_result(1'b0, 8'h00, 1'b1, strobe, kept);
    end else begin
      case (rx_phase)
        PH_IDLE: begin
          if (b == HDR1) begin
            rx_phase = PH_HDR2;
            frame_timer = slave_cfg.frame_timeout_ticks;
          end
        end
        PH_HDR2: begin
          if (b == HDR2) rx_phase = PH_ADDR;
          else if (b == HDR1) frame_timer = slave_cfg.frame_timeout_ticks;
          else begin
            rx_phase = PH_IDLE;
            frame_timer = 8'h00;
          end
        end
        PH_ADDR: begin
          if (b == slave_cfg.device_address || b == BCAST) begin
            held_addr = b;
            rx_phase = PH_CMD;
          end else restart_frame(b);
        end
        PH_CMD: begin
          if (b >= 8'd1 && b <= 8'd4) begin
            held_cmd = b[2:0];
            rx_phase = PH_TAIL1;
          end else restart_frame(b);
        end
        PH_TAIL1: begin
          if (b == HDR2) rx_phase = PH_TAIL2;
          else restart_frame(b);
        end
        PH_TAIL2: begin
          rx_phase = PH_IDLE;
          frame_timer = 8'h00;
          complete = (b == HDR1);
        end
        default: begin
          rx_phase = PH_IDLE;
          frame_timer = 8'h00;
        end
      endcase
      // address is checked again here, it may have been rewritten mid-frame
      if (complete && (held_addr == slave_cfg.device_address || held_addr == BCAST)) begin
        case (held_cmd)
          CMD_ON: begin
            if (!light) begin
              light = 1'b1;
              arm_save();
            end
          end
          CMD_OFF: begin
            if (light) begin
              light = 1'b0;
              arm_save();
            end
          end
          CMD_INVERT: begin
            light = ~light;
            arm_save();
          end
          default: ;
        endcase
        reply = (held_addr == slave_cfg.device_address) ||
                (held_addr == BCAST && slave_cfg.reply_to_broadcast);
      end
      if (reply) begin
        frame_bytes = '{HDR1, HDR2, slave_cfg.device_address, {5'd0, held_cmd},
                        {7'd0, light}, HDR2, HDR1};
        for (int k = 0; k < 7; k++) push_result(1'b1, frame_bytes[k], k == 6, 1'b0, 1'b0);
        reply_frames++;
      end else begin
        push_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, tx_valid %0b tx_byte %0h",
                 $time, tx_valid, tx_byte);
        mismatch_count++;
      end else begin
        want_result = expected_results.pop_front();
        check_field("tx_valid", {7'd0, want_result.tx_valid}, {7'd0, tx_valid});
        check_field("tx_byte", want_result.tx_byte, tx_byte);
        check_field("last", {7'd0, want_result.last}, {7'd0, last});
        check_field("light_on", {7'd0, want_result.light_on}, {7'd0, light_on});
        check_field("save_strobe", {7'd0, want_result.save_strobe}, {7'd0, save_strobe});
        check_field("save_value", {7'd0, want_result.save_value}, {7'd0, save_value});
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      // stall rate is redrawn whenever the pattern counter runs out, zero gives clean stretches
      if (pat_count == 0) begin
        pat_count <= $urandom_range(20, 60);
        stall_pct <= 25 * $urandom_range(0, 3);
      end else begin
        pat_count <= pat_count - 1;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one input transfer, then maybe a gap between bursts
  task automatic send_item(input logic m, input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(m, b);
    items_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(0, 10);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [2:0] cmd);
    send_item(MODE_BYTE, HDR1);
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, addr);
    send_item(MODE_BYTE, {5'd0, cmd});
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, HDR1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEVICE_ADDRESS:     slave_cfg.device_address = val[7:0];
      CFG_FRAME_TIMEOUT:      slave_cfg.frame_timeout_ticks = val[7:0];
      CFG_SAVE_DELAY:         slave_cfg.save_delay_ticks = val;
      CFG_REPLY_TO_BROADCAST: slave_cfg.reply_to_broadcast = val[0];
      default: ;
    endcase
    config_writes++;
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [7:0] timeout,
                            input logic [15:0] delay, input logic bcast_reply);
    wait_idle();
    write_reg(CFG_DEVICE_ADDRESS, {8'h00, addr});
    write_reg(CFG_FRAME_TIMEOUT, {8'h00, timeout});
    write_reg(CFG_SAVE_DELAY, delay);
    write_reg(CFG_REPLY_TO_BROADCAST, {15'd0, bcast_reply});
    cfg_valid <= 1'b0;
  endtask

  // mostly well formed frames, some corrupted, ticks sprinkled in between
  task automatic random_frame();
    logic [7:0] fb [6];
    int r;
    r = $urandom_range(0, 9);
    fb = '{HDR1, HDR2, 8'h00, 8'h00, HDR2, HDR1};
    if (r < 5) fb[2] = slave_cfg.device_address;
    else if (r < 7) fb[2] = BCAST;
    else fb[2] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 8) fb[3] = 8'($urandom_range(1, 4));
    else fb[3] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) fb[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) fb[$urandom_range(2, 4)] = HDR1;
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(0, 99) < 12) send_tick();
      send_item(MODE_BYTE, fb[k]);
    end
  endtask

  task automatic run_random(input int count);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 19);
      if (r < 14) random_frame();
      else if (r < 18) repeat ($urandom_range(1, 4)) send_tick();
      else send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_default_frame();
    send_frame(DEVICE_ADDRESS_RST, CMD_ON);
    send_tick();
  endtask

  // zero timeout never drops a frame, zero save delay fires on the next tick
  task automatic test_zero_settings();
    set_config(8'h00, 8'd0, 16'd0, 1'b1);
    send_item(MODE_BYTE, HDR1);
    send_tick();
    send_tick();
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, {5'd0, CMD_STATUS});
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, HDR1);
    send_frame(BCAST, CMD_INVERT);
    send_tick();
  endtask

  task automatic test_parser_recovery();
    set_config(8'hFE, 8'd2, 16'hFFFF, 1'b0);
    // repeated header while waiting for 18, then a stray 10 in the command slot
    send_item(MODE_BYTE, HDR1);
    send_item(MODE_BYTE, HDR1);
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, 8'hFE);
    send_item(MODE_BYTE, HDR1);
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, 8'hFE);
    send_item(MODE_BYTE, {5'd0, CMD_ON});
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, HDR1);
    // timeout drops the partial frame, then a frame whose closing byte is wrong
    send_item(MODE_BYTE, HDR1);
    send_item(MODE_BYTE, HDR2);
    send_tick();
    send_tick();
    send_item(MODE_BYTE, HDR1);
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, 8'hFE);
    send_item(MODE_BYTE, {5'd0, CMD_INVERT});
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, 8'h11);
    // broadcast acts but stays silent
    send_frame(BCAST, CMD_OFF);
  endtask

  task automatic test_address_change();
    send_item(MODE_BYTE, HDR1);
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, 8'hFE);
    send_item(MODE_BYTE, {5'd0, CMD_ON});
    set_config(8'h05, 8'd2, 16'd1, 1'b0);
    send_item(MODE_BYTE, HDR2);
    send_item(MODE_BYTE, HDR1);
  endtask

  task automatic test_own_broadcast_address();
    set_config(BCAST, 8'd255, 16'd1, 1'b0);
    send_frame(BCAST, CMD_INVERT);
    send_tick();
  endtask

  task automatic test_random_settings();
    logic [7:0]  addr;
    logic [7:0]  timeout;
    logic [15:0] delay;
    for (int i = 0; i < 4; i++) begin
      addr = ($urandom_range(0, 7) == 0) ? BCAST : 8'($urandom_range(0, 254));
      timeout = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(1, 6));
      delay = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(1, 10));
      set_config(addr, timeout, delay, 1'($urandom_range(0, 1)));
      run_random(16);
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    set_config(8'h2A, 8'd4, 16'd3, 1'b1);
    gaps_on = 1'b0;
    hold_req <= ~hold_req;
    repeat (4) random_frame();
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    run_random(12);
    wait_idle();
    run_random(12);
  endtask

  initial begin
    slave_cfg = '{DEVICE_ADDRESS_RST, FRAME_TIMEOUT_RST, SAVE_DELAY_RST, 1'b0};
    rx_phase = PH_IDLE;
    frame_timer = 8'h00;
    held_addr = 8'h00;
    held_cmd = 3'd0;
    light = 1'b0;
    save_armed = 1'b0;
    save_count = 16'h0000;
    save_level = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_frame();
    test_zero_settings();
    test_parser_recovery();
    test_address_change();
    test_own_broadcast_address();
    test_random_settings();
    test_backpressure();
    test_drain_pause();
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d items (%0d ticks), %0d results, %0d reply frames, %0d save strobes",
             items_sent, ticks_sent, results_seen, reply_frames, save_strobes);
    $display("%0d register writes, including zero and full-scale timeout and save delay",
             config_writes);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count,
               expected_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
